// ===== rtl/pdf_sbd_pkg.sv =====
// Shared types and character constants for the PDF string body decoder.
`default_nettype none

package pdf_sbd_pkg;

  localparam logic [7:0] MAX_NEST = 8'd255;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BS     = 8'h08;

  // Hex letters a..f and A..F map to 10..15 through this offset.
  localparam logic [7:0] HEX_LETTER_OFS = 8'd10;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_OPEN    = 2'd1,
    ST_BAD_HEX     = 2'd2,
    ST_HEX_PARTIAL = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       valid;
    logic       done;
    status_t    status;
    logic       last;
  } res_t;

  // Results produced by one input beat: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/pdf_sbd_core.sv =====
// Per-byte decode: parser state registers and the single-pass next-state logic.
`default_nettype none

module pdf_sbd_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 accept,
  input  wire                 cmd,
  input  wire [7:0]           byte_in,
  output pdf_sbd_pkg::push_t  push
);
  import pdf_sbd_pkg::*;

  typedef enum logic [1:0] {
    M_IDLE = 2'd0,
    M_LIT  = 2'd1,
    M_HEX  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    E_NORMAL = 2'd0,
    E_ESC    = 2'd1,
    E_OCT    = 2'd2
  } esc_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] depth;
    esc_t       esc;
    logic [7:0] oval;
    logic [1:0] odig;
    logic [3:0] hnib;
    logic       hhave;
  } st_t;

  typedef struct packed {
    st_t  s;
    logic emit;
    res_t r;
  } plain_t;

  localparam st_t ST_RESET = '{mode: M_IDLE, depth: 8'd0, esc: E_NORMAL, oval: 8'd0,
                               odig: 2'd0, hnib: 4'd0, hhave: 1'b0};

  function automatic res_t mk(input logic [7:0] b, input logic v, input logic d,
                              input status_t s);
    res_t r;
    r.byte_val = b;
    r.valid    = v;
    r.done     = d;
    r.status   = s;
    r.last     = 1'b0;
    return r;
  endfunction

  function automatic logic is_oct(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_SEVEN);
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_VT) ||
           (b == CH_FF) || (b == CH_CR);
  endfunction

  // Ordinary literal byte: nesting, close, start of escape.
  function automatic plain_t lit_plain(input st_t s_in, input logic [7:0] b);
    plain_t p;
    p.s    = s_in;
    p.emit = 1'b1;
    p.r    = mk(b, 1'b1, 1'b0, ST_OK);
    if (b == CH_BSL) begin
      p.s.esc = E_ESC;
      p.emit  = 1'b0;
    end else if (b == CH_LPAREN) begin
      if (s_in.depth < MAX_NEST) begin
        p.s.depth = s_in.depth + 8'd1;
      end
    end else if (b == CH_RPAREN) begin
      if (s_in.depth <= 8'd1) begin
        p.r = mk(8'd0, 1'b0, 1'b1, ST_OK);
        p.s = ST_RESET;
      end else begin
        p.s.depth = s_in.depth - 8'd1;
      end
    end
    return p;
  endfunction

  st_t        st;
  st_t        st_next;
  plain_t     pl;
  res_t       r0;
  res_t       r1;
  logic [1:0] cnt;
  logic [7:0] esc_char;
  logic [4:0] hex_v;   // bit 4 flags a non-digit

  always_comb begin
    case (byte_in)
      CH_LO_N: esc_char = CH_LF;
      CH_LO_R: esc_char = CH_CR;
      CH_LO_T: esc_char = CH_TAB;
      CH_LO_B: esc_char = CH_BS;
      CH_LO_F: esc_char = CH_FF;
      default: esc_char = byte_in;
    endcase
  end

  always_comb begin
    if (byte_in >= CH_ZERO && byte_in <= CH_NINE) begin
      hex_v = {1'b0, 4'(byte_in - CH_ZERO)};
    end else if (byte_in >= CH_LO_A && byte_in <= CH_LO_F) begin
      hex_v = {1'b0, 4'(byte_in - CH_LO_A + HEX_LETTER_OFS)};
    end else if (byte_in >= CH_UP_A && byte_in <= CH_UP_F) begin
      hex_v = {1'b0, 4'(byte_in - CH_UP_A + HEX_LETTER_OFS)};
    end else begin
      hex_v = 5'h10;
    end
  end

  always_comb begin
    st_next = st;
    r0      = mk(8'd0, 1'b0, 1'b0, ST_OK);
    r1      = mk(8'd0, 1'b0, 1'b0, ST_OK);
    cnt     = 2'd0;
    pl      = lit_plain(st, byte_in);
    if (cmd) begin
      st_next = ST_RESET;
      case (st.mode)
        M_LIT: begin
          cnt = 2'd1;
          case (st.esc)
            E_ESC:   r0 = mk(CH_BSL, 1'b1, 1'b1, ST_OK);
            E_OCT:   r0 = mk(st.oval, 1'b1, 1'b1, ST_OK);
            default: r0 = mk(8'd0, 1'b0, 1'b1, ST_OK);
          endcase
        end
        M_HEX: begin
          cnt = 2'd1;
          r0  = mk(8'd0, 1'b0, 1'b1, st.hhave ? ST_HEX_PARTIAL : ST_OK);
        end
        default: ;
      endcase
    end else begin
      case (st.mode)
        M_LIT: begin
          case (st.esc)
            E_ESC: begin
              st_next.esc = E_NORMAL;
              if (is_oct(byte_in)) begin
                st_next.esc  = E_OCT;
                st_next.oval = {5'd0, byte_in[2:0]};
                st_next.odig = 2'd1;
              end else begin
                r0  = mk(esc_char, 1'b1, 1'b0, ST_OK);
                cnt = 2'd1;
              end
            end
            E_OCT: begin
              if (is_oct(byte_in)) begin
                st_next.oval = {st.oval[4:0], byte_in[2:0]};
                st_next.odig = st.odig + 2'd1;
                if (st.odig == 2'd2) begin
                  r0           = mk({st.oval[4:0], byte_in[2:0]}, 1'b1, 1'b0, ST_OK);
                  cnt          = 2'd1;
                  st_next.esc  = E_NORMAL;
                  st_next.oval = 8'd0;
                  st_next.odig = 2'd0;
                end
              end else begin
                // Flush the value, then treat the terminating byte as ordinary.
                st_next      = st;
                st_next.esc  = E_NORMAL;
                st_next.oval = 8'd0;
                st_next.odig = 2'd0;
                pl           = lit_plain(st_next, byte_in);
                st_next      = pl.s;
                r0           = mk(st.oval, 1'b1, 1'b0, ST_OK);
                r1           = pl.r;
                cnt          = pl.emit ? 2'd2 : 2'd1;
              end
            end
            default: begin
              st_next = pl.s;
              r0      = pl.r;
              cnt     = {1'b0, pl.emit};
            end
          endcase
        end
        M_HEX: begin
          if (is_ws(byte_in)) begin
            cnt = 2'd0;
          end else if (byte_in == CH_GT) begin
            cnt     = 2'd1;
            st_next = ST_RESET;
            if (st.hhave) begin
              r0 = mk({st.hnib, 4'd0}, 1'b1, 1'b1, ST_OK);
            end else begin
              r0 = mk(8'd0, 1'b0, 1'b1, ST_OK);
            end
          end else if (hex_v[4]) begin
            cnt     = 2'd1;
            st_next = ST_RESET;
            r0      = mk(8'd0, 1'b0, 1'b1, ST_BAD_HEX);
          end else if (st.hhave) begin
            cnt           = 2'd1;
            r0            = mk({st.hnib, hex_v[3:0]}, 1'b1, 1'b0, ST_OK);
            st_next.hhave = 1'b0;
            st_next.hnib  = 4'd0;
          end else begin
            st_next.hnib  = hex_v[3:0];
            st_next.hhave = 1'b1;
          end
        end
        default: begin
          st_next = ST_RESET;
          if (byte_in == CH_LPAREN) begin
            st_next.mode  = M_LIT;
            st_next.depth = 8'd1;
          end else if (byte_in == CH_LT) begin
            st_next.mode = M_HEX;
          end else begin
            cnt = 2'd1;
            r0  = mk(8'd0, 1'b0, 1'b1, ST_BAD_OPEN);
          end
        end
      endcase
    end
    if (cnt == 2'd2) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  assign push.count = accept ? cnt : 2'd0;
  assign push.r0    = r0;
  assign push.r1    = r1;

endmodule

`default_nettype wire

// ===== rtl/pdf_sbd_outq.sv =====
// Result queue: takes up to two results per cycle while it has room, hands out one per beat.
`default_nettype none

module pdf_sbd_outq (
  input  wire                 clk,
  input  wire                 rst,
  input  pdf_sbd_pkg::push_t  push,
  output logic                room,
  output logic                res_valid,
  input  wire                 res_stall,
  output pdf_sbd_pkg::res_t   head
);
  import pdf_sbd_pkg::*;

  res_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic [QAW:0]   count_next;
  logic           pop;

  assign pop        = res_valid && !res_stall;
  assign count_next = count + (QAW+1)'(push.count) - {{QAW{1'b0}}, pop};
  // Accept a new beat only with room for its worst case of two results.
  assign room       = (count <= (QAW+1)'(QDEPTH - 2));
  assign res_valid  = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + QAW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> room)
    else $error("results pushed without room");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + (QAW+1)'($past(push.count)) -
                               {{QAW{1'b0}}, $past(pop)})
    else $error("queue count out of step with pushes and pops");

endmodule

`default_nettype wire

// ===== rtl/pdf_string_body_decoder.sv =====
// A beat's results are registered in the result queue, behind any earlier results.
// Throughput: one input beat per cycle; a beat yields at most two results and on average
// no more than one, so in_stall rises only when res_stall backs up more than two results.
// Reset (rst, synchronous): parser returns to idle awaiting an opening byte and the
// result queue empties; no clearing pass.
`default_nettype none

module pdf_string_body_decoder (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        cmd,
  input  wire [7:0]  byte_in,
  output logic       res_valid,
  input  wire        res_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       string_done,
  output logic [1:0] status,
  output logic       last
);
  import pdf_sbd_pkg::*;

  push_t push;
  res_t  head;
  logic  room;
  logic  accept;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  pdf_sbd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .cmd     (cmd),
    .byte_in (byte_in),
    .push    (push)
  );

  pdf_sbd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .head      (head)
  );

  assign out_byte    = head.byte_val;
  assign out_valid   = head.valid;
  assign string_done = head.done;
  assign status      = head.status;
  assign last        = head.last;

endmodule

`default_nettype wire

// ===== dv/pdf_string_body_decoder_test.sv =====
// Self-checking testbench for the PDF string body decoder: directed table plus random strings.
module pdf_string_body_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pdf_sbd_pkg::*;

  localparam int LIMIT = 1_000_000;
  localparam int N_RANDOM = 1550;

  localparam logic [7:0] CH_LO_Q = 8'h71;
  localparam logic [7:0] CH_LO_G = 8'h67;
  localparam logic [7:0] CH_ONE = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FIVE = 8'h35;

  typedef enum logic [1:0] {PM_IDLE, PM_LIT, PM_HEX} pmode_t;
  typedef enum logic [1:0] {PE_NONE, PE_BSL, PE_OCT} pesc_t;

  // One input beat; rows with fixed = 1 carry their expected result (has_res) inline.
  typedef struct packed {
    logic       cmd;
    logic [7:0] b;
    logic       fixed;
    logic       has_res;
    res_t       res;
  } stim_t;

  localparam res_t R_NONE = '0;
  localparam res_t R_BAD_OPEN = '{8'h00, 1'b0, 1'b1, ST_BAD_OPEN, 1'b1};
  localparam res_t R_BAD_HEX = '{8'h00, 1'b0, 1'b1, ST_BAD_HEX, 1'b1};
  localparam res_t R_HEX_PART = '{8'h00, 1'b0, 1'b1, ST_HEX_PARTIAL, 1'b1};
  localparam res_t R_ZERO = '{8'h00, 1'b1, 1'b0, ST_OK, 1'b1};
  localparam res_t R_FF = '{8'hFF, 1'b1, 1'b0, ST_OK, 1'b1};

  localparam int N_DIR = 34;
  stim_t dir_tab [N_DIR] = '{
    '{1'b1, 8'h00, 1'b1, 1'b0, R_NONE},      // end of input while idle
    '{1'b0, 8'h00, 1'b1, 1'b1, R_BAD_OPEN},
    '{1'b0, CH_LPAREN, 1'b1, 1'b0, R_NONE},
    '{1'b0, 8'h00, 1'b1, 1'b1, R_ZERO},
    '{1'b0, 8'hFF, 1'b1, 1'b1, R_FF},
    '{1'b0, CH_BSL, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_LO_N, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_BSL, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_LO_Q, 1'b0, 1'b0, R_NONE},    // unknown escape
    '{1'b0, CH_BSL, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_SEVEN, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_SEVEN, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_SEVEN, 1'b0, 1'b0, R_NONE},   // octal wraps to 8 bits
    '{1'b0, CH_BSL, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_ONE, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_RPAREN, 1'b0, 1'b0, R_NONE},  // closing paren ends octal and string
    '{1'b0, CH_LT, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_SPACE, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_LO_A, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_UP_F, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_THREE, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_GT, 1'b0, 1'b0, R_NONE},      // lone nibble padded
    '{1'b0, CH_LT, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_LO_G, 1'b1, 1'b1, R_BAD_HEX},
    '{1'b0, CH_LT, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_ONE, 1'b0, 1'b0, R_NONE},
    '{1'b1, 8'hFF, 1'b1, 1'b1, R_HEX_PART},
    '{1'b0, CH_LPAREN, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_BSL, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_FIVE, 1'b0, 1'b0, R_NONE},
    '{1'b1, 8'h00, 1'b0, 1'b0, R_NONE},      // end inside octal
    '{1'b0, CH_LPAREN, 1'b0, 1'b0, R_NONE},
    '{1'b0, CH_BSL, 1'b0, 1'b0, R_NONE},
    '{1'b1, 8'h55, 1'b0, 1'b0, R_NONE}       // end after lone backslash
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       cmd = 1'b0;
  logic [7:0] byte_in = 8'h00;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       string_done;
  logic [1:0] status;
  logic       last;

  stim_t cur_item = '0;
  stim_t feed_q[$];
  res_t  due_results[$];
  res_t  beat_results[$];
  int    fails = 0;
  int    cycles = 0;
  int    rs_left = 0;
  bit    out_quiet = 1'b0;

  // Decoder shadow state.
  pmode_t     p_mode = PM_IDLE;
  pesc_t      p_esc = PE_NONE;
  logic [7:0] p_depth = '0;
  logic [7:0] p_oct = '0;
  logic [1:0] p_ndig = '0;
  logic [3:0] p_hi = '0;
  logic       p_half = 1'b0;

  pdf_string_body_decoder u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .byte_in(byte_in),
    .res_valid(res_valid), .res_stall(res_stall),
    .out_byte(out_byte), .out_valid(out_valid), .string_done(string_done),
    .status(status), .last(last)
  );

  always #5 clk = ~clk;

  function automatic int hex_nibble(logic [7:0] b);
    if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
    if (b >= CH_LO_A && b <= CH_LO_F) return int'(b - CH_LO_A + HEX_LETTER_OFS);
    if (b >= CH_UP_A && b <= CH_UP_F) return int'(b - CH_UP_A + HEX_LETTER_OFS);
    return -1;
  endfunction

  function automatic bit is_hex_space(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT || b == CH_FF ||
           b == CH_CR;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fails++;
    end
  endfunction

  task automatic push_result(logic [7:0] v, logic vl, logic dn, status_t st);
    res_t r;
    r = '{v, vl, dn, st, 1'b0};
    beat_results.insert(beat_results.size(), r);
  endtask

  task automatic clear_parser();
    p_mode = PM_IDLE;
    p_esc = PE_NONE;
    p_depth = '0;
    p_oct = '0;
    p_ndig = '0;
    p_hi = '0;
    p_half = 1'b0;
  endtask

  task automatic literal_plain(logic [7:0] b);
    if (b == CH_BSL) begin
      p_esc = PE_BSL;
    end else if (b == CH_LPAREN) begin
      // saturate nesting, still pass the paren through
      if (p_depth < MAX_NEST) p_depth++;
      push_result(b, 1'b1, 1'b0, ST_OK);
    end else if (b == CH_RPAREN) begin
      if (p_depth <= 8'd1) begin
        push_result(8'h00, 1'b0, 1'b1, ST_OK);
        clear_parser();
      end else begin
        p_depth--;
        push_result(b, 1'b1, 1'b0, ST_OK);
      end
    end else begin
      push_result(b, 1'b1, 1'b0, ST_OK);
    end
  endtask

  task automatic decode_beat(logic c, logic [7:0] b);
    int nib;
    int idx;
    beat_results.delete();
    nib = hex_nibble(b);
    if (c) begin
      if (p_mode == PM_LIT) begin
        if (p_esc == PE_BSL) push_result(CH_BSL, 1'b1, 1'b1, ST_OK);
        else if (p_esc == PE_OCT) push_result(p_oct, 1'b1, 1'b1, ST_OK);
        else push_result(8'h00, 1'b0, 1'b1, ST_OK);
      end else if (p_mode == PM_HEX) begin
        push_result(8'h00, 1'b0, 1'b1, p_half ? ST_HEX_PARTIAL : ST_OK);
      end
      clear_parser();
    end else if (p_mode == PM_LIT) begin
      if (p_esc == PE_BSL) begin
        p_esc = PE_NONE;
        if (b >= CH_ZERO && b <= CH_SEVEN) begin
          p_esc = PE_OCT;
          p_oct = {5'd0, b[2:0]};
          p_ndig = 2'd1;
        end else begin
          case (b)
            CH_LO_N: push_result(CH_LF, 1'b1, 1'b0, ST_OK);
            CH_LO_R: push_result(CH_CR, 1'b1, 1'b0, ST_OK);
            CH_LO_T: push_result(CH_TAB, 1'b1, 1'b0, ST_OK);
            CH_LO_B: push_result(CH_BS, 1'b1, 1'b0, ST_OK);
            CH_LO_F: push_result(CH_FF, 1'b1, 1'b0, ST_OK);
            default: push_result(b, 1'b1, 1'b0, ST_OK);
          endcase
        end
      end else if (p_esc == PE_OCT) begin
        if (b >= CH_ZERO && b <= CH_SEVEN) begin
          p_oct = {p_oct[4:0], b[2:0]};
          p_ndig++;
          if (p_ndig == 2'd3) begin
            push_result(p_oct, 1'b1, 1'b0, ST_OK);
            p_esc = PE_NONE;
            p_oct = '0;
            p_ndig = '0;
          end
        end else begin
          // flush the octal value, then treat the byte as ordinary
          push_result(p_oct, 1'b1, 1'b0, ST_OK);
          p_esc = PE_NONE;
          p_oct = '0;
          p_ndig = '0;
          literal_plain(b);
        end
      end else begin
        literal_plain(b);
      end
    end else if (p_mode == PM_HEX) begin
      if (is_hex_space(b)) begin
        // skip whitespace
      end else if (b == CH_GT) begin
        if (p_half) push_result({p_hi, 4'h0}, 1'b1, 1'b1, ST_OK);
        else push_result(8'h00, 1'b0, 1'b1, ST_OK);
        clear_parser();
      end else if (nib < 0) begin
        push_result(8'h00, 1'b0, 1'b1, ST_BAD_HEX);
        clear_parser();
      end else if (p_half) begin
        push_result({p_hi, nib[3:0]}, 1'b1, 1'b0, ST_OK);
        p_half = 1'b0;
        p_hi = '0;
      end else begin
        p_hi = nib[3:0];
        p_half = 1'b1;
      end
    end else begin
      clear_parser();
      if (b == CH_LPAREN) begin
        p_mode = PM_LIT;
        p_depth = 8'd1;
      end else if (b == CH_LT) begin
        p_mode = PM_HEX;
      end else begin
        push_result(8'h00, 1'b0, 1'b1, ST_BAD_OPEN);
      end
    end
    if (beat_results.size() > 0) begin
      idx = beat_results.size() - 1;
      beat_results[idx].last = 1'b1;
    end
  endtask

  task automatic feed(logic c, logic [7:0] b);
    stim_t s;
    s = '{c, b, 1'b0, 1'b0, R_NONE};
    feed_q.insert(feed_q.size(), s);
  endtask

  // Result-side backpressure.
  always @(posedge clk) begin
    if ($urandom_range(0, 127) == 0) out_quiet = !out_quiet;
    if (rs_left > 0) begin
      res_stall <= 1'b1;
      rs_left--;
    end else begin
      res_stall <= 1'b0;
      if (!out_quiet && $urandom_range(0, 3) == 0) rs_left = pick_gap();
    end
  end

  // Predict on each accepted input beat, check each accepted result beat.
  always @(posedge clk) begin : scoreboard
    res_t got;
    cycles++;
    if (!rst && in_valid && !in_stall) begin
      decode_beat(cur_item.cmd, cur_item.b);
      if (cur_item.fixed) begin
        if (cur_item.has_res) due_results.insert(due_results.size(), cur_item.res);
      end else begin
        foreach (beat_results[k]) due_results.insert(due_results.size(), beat_results[k]);
      end
    end
    if (!rst && res_valid && !res_stall) begin
      if (due_results.size() == 0) begin
        $error("result with no expectation: out_byte %0h string_done %0b status %0d",
               out_byte, string_done, status);
        fails++;
      end else begin
        got = due_results.pop_front();
        check_field("out_byte", got.byte_val, out_byte);
        check_field("out_valid", 8'(got.valid), 8'(out_valid));
        check_field("string_done", 8'(got.done), 8'(string_done));
        check_field("status", 8'(got.status), 8'(status));
        check_field("last", 8'(got.last), 8'(last));
      end
    end
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int g;
    int n;
    int k;
    int gd;
    int v;
    int drain_at;
    bit deep_done;
    bit in_quiet;
    logic [7:0] b;
    deep_done = 1'b0;
    in_quiet = 1'b0;
    foreach (dir_tab[i]) feed_q.insert(feed_q.size(), dir_tab[i]);

    while (feed_q.size() < N_DIR + N_RANDOM) begin
      k = $urandom_range(0, 99);
      if (!deep_done && feed_q.size() > N_DIR + 400) begin
        // nest past the depth limit, then unwind to the outermost level and close
        deep_done = 1'b1;
        feed(1'b0, CH_LPAREN);
        repeat (256) feed(1'b0, CH_LPAREN);
        feed(1'b0, CH_BSL);
        feed(1'b0, CH_LO_T);
        repeat (254) feed(1'b0, CH_RPAREN);
        feed(1'b0, CH_RPAREN);
      end else if (k < 55) begin
        feed(1'b0, CH_LPAREN);
        gd = 1;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
        repeat (n) begin
          k = $urandom_range(0, 99);
          if (k < 35) begin
            do b = 8'($urandom_range(32, 126));
            while (b == CH_LPAREN || b == CH_RPAREN || b == CH_BSL);
            feed(1'b0, b);
          end else if (k < 45) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_BSL || b == CH_RPAREN) b = b ^ 8'h80;
            if (b == CH_LPAREN) gd++;
            feed(1'b0, b);
          end else if (k < 55) begin
            gd++;
            feed(1'b0, CH_LPAREN);
          end else if (k < 65) begin
            if (gd > 1) begin
              gd--;
              feed(1'b0, CH_RPAREN);
            end
          end else if (k < 80) begin
            feed(1'b0, CH_BSL);
            case ($urandom_range(0, 7))
              0: feed(1'b0, CH_LO_N);
              1: feed(1'b0, CH_LO_R);
              2: feed(1'b0, CH_LO_T);
              3: feed(1'b0, CH_LO_B);
              4: feed(1'b0, CH_LO_F);
              5: feed(1'b0, CH_LPAREN);
              6: feed(1'b0, CH_RPAREN);
              default: feed(1'b0, CH_BSL);
            endcase
          end else if (k < 88) begin
            feed(1'b0, CH_BSL);
            feed(1'b0, 8'($urandom_range(0, 255)));
          end else begin
            feed(1'b0, CH_BSL);
            repeat ($urandom_range(1, 3)) feed(1'b0, CH_ZERO + 8'($urandom_range(0, 7)));
          end
        end
        k = $urandom_range(0, 99);
        if (k < 70) begin
          repeat (gd) feed(1'b0, CH_RPAREN);
        end else if (k < 80) begin
          feed(1'b0, CH_BSL);
          feed(1'b1, 8'($urandom_range(0, 255)));
        end else begin
          feed(1'b1, 8'($urandom_range(0, 255)));
        end
      end else if (k < 85) begin
        feed(1'b0, CH_LT);
        n = $urandom_range(0, 16);
        repeat (n) begin
          if ($urandom_range(0, 99) < 75) begin
            v = $urandom_range(0, 15);
            if (v < 10) b = CH_ZERO + 8'(v);
            else if ($urandom_range(0, 1) == 1) b = CH_LO_A + 8'(v - 10);
            else b = CH_UP_A + 8'(v - 10);
          end else begin
            case ($urandom_range(0, 5))
              0: b = CH_SPACE;
              1: b = CH_TAB;
              2: b = CH_LF;
              3: b = CH_VT;
              4: b = CH_FF;
              default: b = CH_CR;
            endcase
          end
          feed(1'b0, b);
        end
        k = $urandom_range(0, 99);
        if (k < 12) begin
          do b = 8'($urandom_range(0, 255));
          while (hex_nibble(b) >= 0 || is_hex_space(b) || b == CH_GT);
          feed(1'b0, b);
        end else if (k < 70) begin
          feed(1'b0, CH_GT);
        end else begin
          feed(1'b1, 8'($urandom_range(0, 255)));
        end
      end else begin
        // raw noise, closed by an end mark so no string stays open
        repeat ($urandom_range(1, 4))
          feed(($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255)));
        feed(1'b1, 8'($urandom_range(0, 255)));
      end
    end
    feed(1'b1, 8'($urandom_range(0, 255)));
    drain_at = N_DIR + (feed_q.size() - N_DIR) / 2;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < feed_q.size(); i++) begin
      if (i == N_DIR || i == drain_at) begin
        // hold off until every predicted result has been seen
        in_valid <= 1'b0;
        do @(posedge clk);
        while (due_results.size() != 0);
      end
      if ($urandom_range(0, 63) == 0) in_quiet = !in_quiet;
      g = in_quiet ? 0 : pick_gap();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      in_valid <= 1'b1;
      cmd <= feed_q[i].cmd;
      byte_in <= feed_q[i].b;
      cur_item <= feed_q[i];
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;

    do @(posedge clk);
    while (due_results.size() != 0);
    repeat (16) @(posedge clk);

    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pdf_sbd_pkg.sv
rtl/pdf_sbd_core.sv
rtl/pdf_sbd_outq.sv
rtl/pdf_string_body_decoder.sv
dv/pdf_string_body_decoder_test.sv
